FILE: rtl/mwrf_pkg.sv
// ----------------------------------------------------------------------------
// mwrf_pkg
// Shared types and constants of the maximal white rectangle finder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mwrf_pkg;

    // Column run heights saturate at the all-ones value.
    localparam int HGT_W = 11;
    localparam logic [HGT_W-1:0] HGT_MAX = '1;

    // Configuration register widths.
    localparam int FW_W    = 7;
    localparam int FH_W    = 11;
    localparam int MA_W    = 17;
    localparam int CFG_I_W = 2;
    localparam int CFG_D_W = 17;

    // Configuration register indexes.
    localparam logic [CFG_I_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_I_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_I_W-1:0] CFG_MIN_AREA     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [FW_W-1:0] FW_RST = 7'd64;
    localparam logic [FH_W-1:0] FH_RST = 11'd1024;
    localparam logic [MA_W-1:0] MA_RST = 17'd1;

    // Result field widths.
    localparam int RX_W = 6;
    localparam int RY_W = 10;
    localparam int RW_W = 7;

    // Area of a rectangle: width times height.
    localparam int AREA_W = RW_W + HGT_W;

    typedef struct packed {
        logic [RX_W-1:0]  x;
        logic [RY_W-1:0]  y;
        logic [RW_W-1:0]  w;
        logic [HGT_W-1:0] h;
    } t_rect;

endpackage

FILE: rtl/mwrf_height_ram.sv
// ----------------------------------------------------------------------------
// mwrf_height_ram
// Column run height memory with one valid bit per column for fast clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwrf_height_ram #(
    parameter int MAX_COLS = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [$clog2(MAX_COLS)-1:0]       i_addr,
    input  logic                              i_wr_en,
    input  logic [mwrf_pkg::HGT_W-1:0]        i_wr_data,
    input  logic                              i_clr,
    output logic [mwrf_pkg::HGT_W-1:0]        o_rd_data
);
    import mwrf_pkg::*;

    logic [HGT_W-1:0]    r_mem [MAX_COLS];
    logic [MAX_COLS-1:0] r_vld;
    logic [HGT_W-1:0]    r_rd;
    logic                r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        r_rd <= r_mem[i_addr];
    end

    // A column that was never written since the last frame end reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[i_addr];
            if (i_clr) begin
                r_vld <= '0;
            end else if (i_wr_en) begin
                r_vld[i_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd : '0;

endmodule

FILE: rtl/mwrf_stack_ram.sv
// ----------------------------------------------------------------------------
// mwrf_stack_ram
// Run stack memory holding start column and height of each open run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mwrf_stack_ram #(
    parameter int MAX_COLS = 64
) (
    input  logic                                           i_clk,
    input  logic                                           i_wr_en,
    input  logic [$clog2(MAX_COLS)-1:0]                    i_wr_addr,
    input  logic [$clog2(MAX_COLS)+mwrf_pkg::HGT_W-1:0]    i_wr_data,
    input  logic [$clog2(MAX_COLS)-1:0]                    i_rd_addr,
    output logic [$clog2(MAX_COLS)+mwrf_pkg::HGT_W-1:0]    o_rd_data
);
    import mwrf_pkg::*;

    localparam int CW = $clog2(MAX_COLS);
    localparam int EW = CW + HGT_W;

    logic [EW-1:0] r_mem [MAX_COLS];
    logic [EW-1:0] r_rd;

    // A push and a read of the same entry in one cycle forward the new entry.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_wr_en && (i_wr_addr == i_rd_addr)) begin
            r_rd <= i_wr_data;
        end else begin
            r_rd <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd;

endmodule

FILE: rtl/maximal_white_rectangle_finder_unit.sv
// ----------------------------------------------------------------------------
// maximal_white_rectangle_finder_unit
// Takes a binary image in raster order, one pixel per request, keeps the run
// height of set pixels per column in a memory and runs a monotone stack per
// row in a second memory. Every popped run whose area reaches the minimum area
// is sent out as a rectangle; the last rectangle caused by a pixel carries
// last_of_run. A pixel goes through the height update, the pops and the push
// before its finish step; the last pixel of a row then also pops every entry
// above a zero-height sentinel. The pop rate is set by the single read port
// of the stack memory, which delivers one new top entry per cycle unless a
// new rectangle waits on a stalled output. The output register lets the next
// pixel be taken while a rectangle still waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module maximal_white_rectangle_finder_unit #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_pixel_set,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [mwrf_pkg::RX_W-1:0]       o_rect_x,
    output logic [mwrf_pkg::RY_W-1:0]       o_rect_y,
    output logic [mwrf_pkg::RW_W-1:0]       o_rect_width,
    output logic [mwrf_pkg::HGT_W-1:0]      o_rect_height,
    output logic                            o_last_of_run,
    input  logic                            i_wr_en,
    input  logic [mwrf_pkg::CFG_I_W-1:0]    i_wr_idx,
    input  logic [mwrf_pkg::CFG_D_W-1:0]    i_wr_data
);
    import mwrf_pkg::*;

    localparam int CW   = $clog2(MAX_COLS);
    localparam int DW   = $clog2(MAX_COLS + 1);
    localparam int RW   = $clog2(MAX_ROWS);
    localparam int EW   = CW + HGT_W;
    localparam int EH_W = 17;

    localparam logic [DW-1:0]   DEPTH_MAX = DW'(MAX_COLS);
    localparam logic [FW_W-1:0] COLS_V    = FW_W'(MAX_COLS);
    localparam logic [EH_W-1:0] ROWS_V    = EH_W'(MAX_ROWS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HGT  = 2'd1;
    localparam logic [1:0] ST_POP  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // Control registers.
    logic [1:0]      r_state,   n_state;
    logic [CW-1:0]   r_col,     n_col;
    logic [RW-1:0]   r_row,     n_row;
    logic [DW-1:0]   r_depth,   n_depth;
    logic            r_flush,   n_flush;
    logic            r_row_end, n_row_end;
    logic            r_pend_vld, n_pend_vld;
    logic            r_out_vld, n_out_vld;
    logic [FW_W-1:0] r_fw;
    logic [FH_W-1:0] r_fh;
    logic [MA_W-1:0] r_ma;

    // Payload registers.
    logic            r_pix,     n_pix;
    logic [HGT_W-1:0] r_cur,    n_cur;
    logic [CW-1:0]   r_start,   n_start;
    logic [DW-1:0]   r_colref,  n_colref;
    t_rect           r_pend,    n_pend;
    t_rect           r_out,     n_out;
    logic            r_out_last, n_out_last;

    // Memory interfaces.
    logic [HGT_W-1:0] hgt_rd;
    logic [HGT_W-1:0] hgt_new;
    logic             hgt_wr_en;
    logic             hgt_clr;
    logic             stk_wr_en;
    logic [CW-1:0]    stk_rd_addr;
    logic [EW-1:0]    stk_rd;

    // Datapath.
    logic [FW_W-1:0]  ew;
    logic [EH_W-1:0]  eh;
    logic [CW-1:0]    top_start;
    logic [HGT_W-1:0] top_h;
    logic [RW_W-1:0]  width_c;
    logic [AREA_W-1:0] area;
    logic             pop_hit;
    logic             qual;
    logic             out_free;
    t_rect            cand;

    mwrf_height_ram #(
        .MAX_COLS (MAX_COLS)
    ) u_height_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_addr    (r_col),
        .i_wr_en   (hgt_wr_en),
        .i_wr_data (hgt_new),
        .i_clr     (hgt_clr),
        .o_rd_data (hgt_rd)
    );

    mwrf_stack_ram #(
        .MAX_COLS (MAX_COLS)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_wr_en),
        .i_wr_addr (CW'(r_depth)),
        .i_wr_data ({r_start, r_cur}),
        .i_rd_addr (stk_rd_addr),
        .o_rd_data (stk_rd)
    );

    // Effective frame size, clamped to the supported range.
    always_comb begin
        if (r_fw == '0) begin
            ew = FW_W'(1);
        end else if (r_fw > COLS_V) begin
            ew = COLS_V;
        end else begin
            ew = r_fw;
        end
        if (r_fh == '0) begin
            eh = EH_W'(1);
        end else if (EH_W'(r_fh) > ROWS_V) begin
            eh = ROWS_V;
        end else begin
            eh = EH_W'(r_fh);
        end
    end

    assign hgt_new   = !r_pix ? '0 : ((hgt_rd == HGT_MAX) ? HGT_MAX : hgt_rd + 1'b1);
    assign top_start = stk_rd[EW-1:HGT_W];
    assign top_h     = stk_rd[HGT_W-1:0];
    assign width_c   = RW_W'(r_colref - DW'(top_start));
    assign area      = AREA_W'(width_c) * AREA_W'(top_h);
    assign pop_hit   = (r_depth != '0) && (top_h > r_cur);
    assign qual      = area >= AREA_W'(r_ma);
    assign out_free  = !r_out_vld || !i_stall;

    always_comb begin
        cand.x = RX_W'(top_start);
        cand.y = RY_W'(r_row) + RY_W'(1) - top_h[RY_W-1:0];
        cand.w = width_c;
        cand.h = top_h;
    end

    // The stack memory always reads the entry that will be on top next cycle.
    assign stk_rd_addr = CW'(n_depth - DW'(1));

    always_comb begin
        n_state    = r_state;
        n_col      = r_col;
        n_row      = r_row;
        n_depth    = r_depth;
        n_flush    = r_flush;
        n_row_end  = r_row_end;
        n_pend_vld = r_pend_vld;
        n_out_vld  = r_out_vld;
        n_pix      = r_pix;
        n_cur      = r_cur;
        n_start    = r_start;
        n_colref   = r_colref;
        n_pend     = r_pend;
        n_out      = r_out;
        n_out_last = r_out_last;
        hgt_wr_en  = 1'b0;
        hgt_clr    = 1'b0;
        stk_wr_en  = 1'b0;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_pix   = i_pixel_set;
                    n_state = ST_HGT;
                end
            end
            ST_HGT: begin
                hgt_wr_en = 1'b1;
                n_cur     = hgt_new;
                n_start   = r_col;
                n_colref  = DW'(r_col);
                n_flush   = 1'b0;
                n_row_end = (8'(r_col) + 8'd1) >= 8'(ew);
                n_state   = ST_POP;
            end
            ST_POP: begin
                if (pop_hit) begin
                    // A new rectangle needs the pending one moved out first.
                    if (!(qual && r_pend_vld && !out_free)) begin
                        n_depth = r_depth - DW'(1);
                        n_start = top_start;
                        if (qual) begin
                            if (r_pend_vld) begin
                                n_out_vld  = 1'b1;
                                n_out      = r_pend;
                                n_out_last = 1'b0;
                            end
                            n_pend_vld = 1'b1;
                            n_pend     = cand;
                        end
                    end
                end else if (r_flush) begin
                    n_depth = '0;
                    n_state = ST_FIN;
                end else begin
                    if (r_depth < DEPTH_MAX) begin
                        stk_wr_en = 1'b1;
                        n_depth   = r_depth + DW'(1);
                    end
                    if (r_row_end) begin
                        // Zero-height sentinel just past the last column.
                        n_flush  = 1'b1;
                        n_cur    = '0;
                        n_colref = DW'(r_col) + DW'(1);
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out      = r_pend;
                        n_out_last = 1'b1;
                        n_pend_vld = 1'b0;
                    end
                    if (r_row_end) begin
                        n_col = '0;
                        if ((EH_W'(r_row) + EH_W'(1)) >= eh) begin
                            n_row   = '0;
                            hgt_clr = 1'b1;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else begin
                        n_col = r_col + CW'(1);
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_col      <= '0;
            r_row      <= '0;
            r_depth    <= '0;
            r_flush    <= 1'b0;
            r_row_end  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fw       <= FW_RST;
            r_fh       <= FH_RST;
            r_ma       <= MA_RST;
        end else begin
            r_state    <= n_state;
            r_col      <= n_col;
            r_row      <= n_row;
            r_depth    <= n_depth;
            r_flush    <= n_flush;
            r_row_end  <= n_row_end;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
            if (i_wr_en) begin
                unique case (i_wr_idx)
                    CFG_FRAME_WIDTH:  r_fw <= i_wr_data[FW_W-1:0];
                    CFG_FRAME_HEIGHT: r_fh <= i_wr_data[FH_W-1:0];
                    CFG_MIN_AREA:     r_ma <= i_wr_data[MA_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix      <= n_pix;
        r_cur      <= n_cur;
        r_start    <= n_start;
        r_colref   <= n_colref;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_last <= n_out_last;
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_out_vld;
    assign o_rect_x      = r_out.x;
    assign o_rect_y      = r_out.y;
    assign o_rect_width  = r_out.w;
    assign o_rect_height = r_out.h;
    assign o_last_of_run = r_out_last;

    // The stack never holds more runs than there are columns.
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= DEPTH_MAX)
        else $error("run stack depth exceeds column count");

    // The column counter stays inside the height memory.
    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        DW'(r_col) < DEPTH_MAX)
        else $error("column counter out of range");

    // No rectangle is left pending once a pixel is finished.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_vld)
        else $error("pending rectangle left behind at idle");

    // The stack is empty after the end of a row.
    a_row_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && r_row_end && !r_pend_vld) |=> (r_depth == '0))
        else $error("run stack not empty after row end");

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the maximal white rectangle finder. Pixels are fed
// through the request channel with random gaps, and the rectangle channel is
// stalled at random. Every accepted pixel is run through a histogram-stack
// predictor kept in the bench, and each rectangle that comes out is compared
// field by field with the oldest predicted one. Frame geometry and the area
// threshold are changed between phases, out-of-range values included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import mwrf_pkg::*;

    localparam int COLS           = 64;
    localparam int ROWS           = 1024;
    localparam int DRAIN_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int MAX_WAIT       = 17;

    // Index with no register behind it; the block must ignore writes to it.
    localparam logic [CFG_I_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_rect box;
        logic  last;
    } t_found_rect;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    logic                i_pixel_set = 1'b0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    logic [RX_W-1:0]     o_rect_x;
    logic [RY_W-1:0]     o_rect_y;
    logic [RW_W-1:0]     o_rect_width;
    logic [HGT_W-1:0]    o_rect_height;
    logic                o_last_of_run;
    logic                i_wr_en     = 1'b0;
    logic [CFG_I_W-1:0]  i_wr_idx    = '0;
    logic [CFG_D_W-1:0]  i_wr_data   = '0;

    maximal_white_rectangle_finder_unit #(
        .MAX_COLS(COLS),
        .MAX_ROWS(ROWS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_set   (i_pixel_set),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rect_x      (o_rect_x),
        .o_rect_y      (o_rect_y),
        .o_rect_width  (o_rect_width),
        .o_rect_height (o_rect_height),
        .o_last_of_run (o_last_of_run),
        .i_wr_en       (i_wr_en),
        .i_wr_idx      (i_wr_idx),
        .i_wr_data     (i_wr_data)
    );

    // Predictor state, a private copy of what the block should hold.
    logic [FW_W-1:0]   cfg_fw = FW_RST;
    logic [FH_W-1:0]   cfg_fh = FH_RST;
    logic [MA_W-1:0]   cfg_ma = MA_RST;
    logic [HGT_W-1:0]  col_hgt   [COLS];
    logic [RX_W-1:0]   run_start [COLS];
    logic [HGT_W-1:0]  run_hgt   [COLS];
    logic [RW_W-1:0]   run_depth = '0;
    logic [RX_W-1:0]   col_cnt   = '0;
    logic [RY_W-1:0]   row_cnt   = '0;

    logic              pixel_feed[$];
    t_found_rect       pending_rects[$];
    t_found_rect       want_rect;

    bit                in_gaps_on  = 1'b1;
    bit                out_gaps_on = 1'b1;
    int unsigned       feed_gap    = 0;
    int unsigned       out_hold    = 0;
    int unsigned       quiet_cycles = 0;
    int unsigned       pixels_taken = 0;
    int unsigned       rects_checked = 0;
    int unsigned       settings_applied = 0;
    int unsigned       mismatches = 0;

    initial begin
        foreach (col_hgt[i]) col_hgt[i] = '0;
        foreach (run_start[i]) run_start[i] = '0;
        foreach (run_hgt[i]) run_hgt[i] = '0;
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_cols();
        if (cfg_fw == 0) return 1;
        if (cfg_fw > COLS) return COLS;
        return cfg_fw;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_fh == 0) return 1;
        if (cfg_fh > ROWS) return ROWS;
        return cfg_fh;
    endfunction

    function automatic int unsigned draw_wait(input bit on);
        if (!on || $urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Pops every run taller than cur; each popped run that covers enough area
    // becomes an expected rectangle ending just left of col_end.
    function automatic void pop_taller(input int unsigned cur, input int unsigned col_end,
                                       inout int unsigned start, inout int unsigned n);
        int unsigned top_h, top_s, wid;
        t_found_rect r;
        while (run_depth > 0 && run_hgt[run_depth - 1] > cur) begin
            top_h = run_hgt[run_depth - 1];
            top_s = run_start[run_depth - 1];
            wid = col_end - top_s;
            run_depth = run_depth - 1'b1;
            if (wid * top_h >= cfg_ma && n < COLS) begin
                r.box.x = RX_W'(top_s);
                r.box.y = RY_W'(row_cnt + 1 - top_h);
                r.box.w = RW_W'(wid);
                r.box.h = HGT_W'(top_h);
                r.last = 1'b0;
                pending_rects.insert(pending_rects.size(), r);
                n++;
            end
            start = top_s;
        end
    endfunction

    function automatic void histogram_step(input logic px);
        int unsigned col, h, start, n;
        col = col_cnt;
        h = col_hgt[col];
        if (px) h = (h < HGT_MAX) ? h + 1 : HGT_MAX;
        else h = 0;
        col_hgt[col] = HGT_W'(h);
        start = col;
        n = 0;
        pop_taller(h, col, start, n);
        if (run_depth < COLS) begin
            run_start[run_depth] = RX_W'(start);
            run_hgt[run_depth] = HGT_W'(h);
            run_depth = run_depth + 1'b1;
        end
        if (col + 1 >= eff_cols()) begin
            // End of row: a zero-height sentinel flushes whatever is stacked.
            start = col + 1;
            pop_taller(0, col + 1, start, n);
            run_depth = '0;
            col_cnt = '0;
            if (row_cnt + 1 >= eff_rows()) begin
                row_cnt = '0;
                foreach (col_hgt[i]) col_hgt[i] = '0;
            end else begin
                row_cnt = row_cnt + 1'b1;
            end
        end else begin
            col_cnt = RX_W'(col + 1);
        end
        if (n > 0) begin
            pending_rects[pending_rects.size() - 1].last = 1'b1;
        end
    endfunction

    // Pixel request driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (i_valid && !o_stall) begin
                histogram_step(i_pixel_set);
                pixels_taken++;
            end
            if (!i_valid || !o_stall) begin
                if (feed_gap > 0) begin
                    i_valid <= 1'b0;
                    feed_gap--;
                end else if (pixel_feed.size() > 0) begin
                    i_valid <= 1'b1;
                    i_pixel_set <= pixel_feed.pop_front();
                    feed_gap = draw_wait(in_gaps_on);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Rectangle monitor and output stall generator.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            out_hold = 0;
        end else begin
            if (o_valid && !i_stall) begin
                rects_checked++;
                if (pending_rects.size() == 0) begin
                    $error("rectangle with no expectation: x=%0d y=%0d width=%0d height=%0d",
                           o_rect_x, o_rect_y, o_rect_width, o_rect_height);
                    mismatches++;
                end else begin
                    want_rect = pending_rects.pop_front();
                    check_field("rect_x", want_rect.box.x, o_rect_x);
                    check_field("rect_y", want_rect.box.y, o_rect_y);
                    check_field("rect_width", want_rect.box.w, o_rect_width);
                    check_field("rect_height", want_rect.box.h, o_rect_height);
                    check_field("last_of_run", want_rect.last, o_last_of_run);
                end
                out_hold = draw_wait(out_gaps_on);
            end else if (!o_valid && out_hold == 0 && out_gaps_on &&
                         $urandom_range(0, 7) == 0) begin
                // Stall ahead of time so the first rectangle of a burst can meet it.
                out_hold = draw_wait(1'b1);
            end
            if (out_hold > 0) begin
                i_stall <= 1'b1;
                out_hold--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog: no request accepted for %0d cycles", quiet_cycles);
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Waits until every pixel is taken and every rectangle has arrived, then
    // gives a pixel that produces nothing time to finish inside the block.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pixel_feed.size() != 0 || i_valid || pending_rects.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_I_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        @(posedge i_clk);
        i_wr_en <= 1'b1;
        i_wr_idx <= idx;
        i_wr_data <= data;
        case (idx)
            CFG_FRAME_WIDTH: cfg_fw = data[FW_W-1:0];
            CFG_FRAME_HEIGHT: cfg_fh = data[FH_W-1:0];
            CFG_MIN_AREA: cfg_ma = data[MA_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_wr_en <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_D_W-1:0] fw, input logic [CFG_D_W-1:0] fh,
                             input logic [CFG_D_W-1:0] ma);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, fw);
        write_reg(CFG_FRAME_HEIGHT, fh);
        write_reg(CFG_MIN_AREA, ma);
        settings_applied++;
    endtask

    task automatic queue_bits(input logic [31:0] bits, input int count);
        @(negedge i_clk);
        for (int i = count - 1; i >= 0; i--) pixel_feed.insert(pixel_feed.size(), bits[i]);
    endtask

    task automatic queue_pixels(input int unsigned count, input int unsigned set_pct);
        @(negedge i_clk);
        repeat (count) pixel_feed.insert(pixel_feed.size(), $urandom_range(0, 99) < set_pct);
    endtask

    // Brings the block back to column 0 of row 0 with all heights cleared.
    task automatic restart_frame();
        configure(1, 1, 1);
        queue_bits(1'b0, 1);
    endtask

    function automatic logic [CFG_D_W-1:0] pad_noise(input int unsigned value,
                                                    input int unsigned width);
        logic [CFG_D_W-1:0] upper;
        upper = CFG_D_W'($urandom) << width;
        return ($urandom_range(0, 1) != 0) ? (upper | CFG_D_W'(value)) : CFG_D_W'(value);
    endfunction

    initial begin : stimulus
        int unsigned fw, fh, ma, cnt, pct, random_pixels;
        random_pixels = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small frame, every run reported; equal heights and a frame wrap.
        configure(4, 3, 0);
        queue_bits(12'b1111_1011_0110, 12);

        // Zero width and height clamp to a single pixel per frame.
        configure(0, 0, 1);
        queue_bits(3'b110, 3);
        wait_idle();
        write_reg(CFG_UNUSED, '1);

        // Width shrinks below the current column, then height below the current row.
        configure(6, 4, 2);
        queue_bits(3'b111, 3);
        wait_idle();
        write_reg(CFG_FRAME_WIDTH, 2);
        queue_bits(2'b11, 2);
        wait_idle();
        write_reg(CFG_FRAME_HEIGHT, 1);
        queue_bits(2'b11, 2);

        while (random_pixels < 32) begin
            case ($urandom_range(0, 9))
                0: fw = 0;
                1: fw = $urandom_range(COLS, (1 << FW_W) - 1);
                default: fw = $urandom_range(1, 10);
            endcase
            case ($urandom_range(0, 9))
                0: fh = 0;
                1: fh = $urandom_range(ROWS + 1, (1 << FH_W) - 1);
                default: fh = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 9))
                0: ma = $urandom_range(0, (1 << MA_W) - 1);
                1: ma = 0;
                default: ma = $urandom_range(1, 8);
            endcase
            configure(pad_noise(fw, FW_W), pad_noise(fh, FH_W), CFG_D_W'(ma));
            in_gaps_on = ($urandom_range(0, 3) != 0);
            out_gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
                0: pct = 50;
                1: pct = 80;
                default: pct = 95;
            endcase
            cnt = (eff_cols() > 16) ? $urandom_range(8, 24) :
                  $urandom_range(1, 3) * eff_cols() + $urandom_range(0, eff_cols() - 1);
            queue_pixels(cnt, pct);
            random_pixels += cnt;
        end

        // A full-width row of equal height fills the stack; the flush empties it.
        restart_frame();
        configure((1 << FW_W) - 1, 2, 1);
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;
        queue_pixels(COLS, 100);

        wait_idle();
        $display("Sent %0d pixels under %0d register settings; %0d rectangles compared.",
                 pixels_taken, settings_applied, rects_checked);
        $display("Field mismatches and unexpected rectangles: %0d", mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mwrf_pkg.sv
rtl/mwrf_height_ram.sv
rtl/mwrf_stack_ram.sv
rtl/maximal_white_rectangle_finder_unit.sv
tb/tb.sv
